### rtl/flba_pkg.sv
`timescale 1ns / 1ps
package flba_pkg;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam logic [16:0] HeaderBytes = 17'd4;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0, CMD_ALLOC = 2'd1, CMD_FREE = 2'd2, CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_FULL = 2'd2, ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0, FIT_NEXT = 2'd1, FIT_BEST = 2'd2, FIT_WORST = 2'd3
  } fit_t;

  localparam logic CFG_FIT = 1'b0;
  localparam logic CFG_ARENA = 1'b1;

  // one table entry: start, size (17 bits so sums never wrap), free flag
  typedef struct packed {
    logic [16:0] start;
    logic [16:0] size;
    logic        free;
  } entry_t;
endpackage

### rtl/free_list_block_allocator.sv
`timescale 1ns / 1ps
// Variable-size arena allocator. One command item (init, allocate, free) is
// taken at a time; in_tready stays low while it is worked. The block table
// lives in a memory of MaxBlocks entries with one read and one write port,
// worked by a small sequencer: init rewrites entry 0 at the edge that takes
// it; allocate scans the table and then shifts the tail up one entry for a
// split; free scans for the offset and shifts the tail down for each merge.
// No clearing pass follows reset: the table is written at entry 0 in the
// boot state after reset, before the first item is taken. The result waits
// in an output register.
module free_list_block_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // cmd[1:0], request_size[17:2], region_offset[33:18]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // status[1:0], granted_offset[17:2], block_size[33:18]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import flba_pkg::*;

  typedef enum logic [9:0] {
    S_BOOT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_SRD   = 10'b0000000100,
    S_SCMP  = 10'b0000001000,
    S_PRD   = 10'b0000010000,
    S_PDEC  = 10'b0000100000,
    S_MVRD  = 10'b0001000000,
    S_MVWR  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  entry_t mem [MaxBlocks];
  entry_t rd_q;
  logic [IdxW-1:0] raddr, waddr;
  logic we;
  entry_t wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [1:0]  fit_r;
  logic [15:0] arena_r;
  logic [1:0]  cmd_r;
  logic [16:0] req_r;
  logic [15:0] off_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic [IdxW-1:0] rove_r, rove_nxt;
  logic [CntW-1:0] k_r, k_nxt;        // scan step
  logic [IdxW-1:0] i_r, i_nxt;        // current entry
  logic found_r, found_nxt;
  logic [IdxW-1:0] pick_r, pick_nxt;
  entry_t pe_r, pe_nxt;               // picked entry
  entry_t ne_r, ne_nxt;               // neighbor/aux entry
  // phase: alloc 0 split-shift; free 0-1 probe next, 2-3 probe prev, 4-5 shift
  logic [2:0] ph_r, ph_nxt;
  logic [IdxW-1:0] mv_r, mv_nxt;      // move index
  logic [IdxW-1:0] mvend_r, mvend_nxt;
  logic mvup_r, mvup_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [15:0] ooff_r, ooff_nxt, osz_r, osz_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, osz_r, ooff_r, ost_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= FIT_FIRST;
      arena_r <= 16'd4096;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FIT) fit_r <= cfg_data[1:0];
      else arena_r <= cfg_data;
    end
  end

  logic [16:0] init_size;
  assign init_size = (arena_r >= 16'd4) ? {1'b0, arena_r} - HeaderBytes : 17'd0;

  // next-fit index: (rove + k) mod count, k < count
  logic [CntW:0] rsum;
  logic [IdxW-1:0] scan_idx;
  always_comb begin
    rsum = {1'b0, {(CntW-IdxW){1'b0}}, rove_r} + {1'b0, k_r};
    if (rsum >= {1'b0, count_r}) rsum = rsum - {1'b0, count_r};
    scan_idx = (fit_r == FIT_NEXT) ? rsum[IdxW-1:0] : k_r[IdxW-1:0];
  end

  logic [CntW-1:0] pick1;
  assign pick1 = {{(CntW-IdxW){1'b0}}, pick_r} + 1'b1;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; rove_nxt = rove_r;
    k_nxt = k_r; i_nxt = i_r; found_nxt = found_r; pick_nxt = pick_r;
    pe_nxt = pe_r; ne_nxt = ne_r; ph_nxt = ph_r; mv_nxt = mv_r;
    mvend_nxt = mvend_r; mvup_nxt = mvup_r;
    ost_nxt = ost_r; ooff_nxt = ooff_r; osz_nxt = osz_r;
    raddr = i_r; waddr = '0; we = 1'b0; wdata = '0;
    case (state_r)
      S_BOOT: begin
        we = 1'b1; wdata = '{start: HeaderBytes, size: init_size, free: 1'b1};
        count_nxt = CntW'(1); rove_nxt = '0; state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          ost_nxt = ST_OK; ooff_nxt = '0; osz_nxt = '0;
          k_nxt = '0; found_nxt = 1'b0; ph_nxt = '0;
          case (in_tdata[1:0])
            CMD_INIT: begin
              we = 1'b1; wdata = '{start: HeaderBytes, size: init_size, free: 1'b1};
              count_nxt = CntW'(1); rove_nxt = '0; state_nxt = S_OUT;
            end
            CMD_ALLOC, CMD_FREE: begin
              if ({{(CntW-IdxW){1'b0}}, rove_r} >= count_r) rove_nxt = '0;
              state_nxt = S_SRD;
            end
            default: state_nxt = S_OUT;
          endcase
          if (in_tdata[1:0] == CMD_INIT) osz_nxt = init_size[15:0];
        end
      end
      S_SRD: begin
        if (k_r >= count_r) begin
          if (cmd_r == CMD_ALLOC && found_r) state_nxt = S_PDEC;
          else begin
            ost_nxt = (cmd_r == CMD_ALLOC) ? ST_NOFIT : ST_BADFREE;
            state_nxt = S_OUT;
          end
        end else begin
          i_nxt = (cmd_r == CMD_ALLOC) ? scan_idx : k_r[IdxW-1:0];
          raddr = i_nxt;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        k_nxt = k_r + 1'b1;
        state_nxt = S_SRD;
        if (cmd_r == CMD_ALLOC) begin
          if (rd_q.free && rd_q.size >= req_r) begin
            if (!found_r ||
                (fit_r == FIT_BEST && rd_q.size < pe_r.size) ||
                (fit_r == FIT_WORST && rd_q.size > pe_r.size)) begin
              found_nxt = 1'b1; pick_nxt = i_r; pe_nxt = rd_q;
            end
            if (!found_r && (fit_r == FIT_FIRST || fit_r == FIT_NEXT))
              state_nxt = S_PDEC;
          end
        end else if (rd_q.start == {1'b0, off_r} && !rd_q.free) begin
          pick_nxt = i_r; pe_nxt = rd_q; pe_nxt.free = 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_PDEC: begin
        // alloc decision after pick
        if (pe_r.size > req_r + HeaderBytes) begin
          if (count_r >= CntW'(MaxBlocks)) begin
            ost_nxt = ST_FULL; state_nxt = S_OUT;
          end else begin
            ne_nxt = '{start: pe_r.start + req_r + HeaderBytes,
                       size: pe_r.size - req_r - HeaderBytes, free: 1'b1};
            pe_nxt.size = req_r;
            // shift entries pick+1 .. count-1 up by one, from the top
            mv_nxt = count_r[IdxW-1:0]; mvend_nxt = pick1[IdxW-1:0]; mvup_nxt = 1'b1;
            state_nxt = S_MVRD;
          end
        end else state_nxt = S_FIN;
      end
      S_PRD: begin
        // free: ph 0 read next, 1 check next, 2 read prev, 3 check prev
        case (ph_r)
          3'd0: begin
            if (pick1 < count_r) begin
              raddr = pick1[IdxW-1:0]; ph_nxt = 3'd1;
            end else ph_nxt = 3'd2;
          end
          3'd1: begin
            ph_nxt = 3'd2;
            if (rd_q.free) begin
              pe_nxt.size = pe_r.size + rd_q.size + HeaderBytes;
              mv_nxt = pick1[IdxW-1:0]; mvup_nxt = 1'b0;
              mvend_nxt = IdxW'(count_r - 1'b1);
              ph_nxt = 3'd4;
              state_nxt = S_MVRD;
            end
          end
          3'd2: begin
            if (pick_r != '0) begin
              raddr = pick_r - 1'b1; ph_nxt = 3'd3;
            end else state_nxt = S_FIN;
          end
          3'd3: begin
            state_nxt = S_FIN;
            if (rd_q.free) begin
              ne_nxt = rd_q;
              ne_nxt.size = rd_q.size + pe_r.size + HeaderBytes;
              pe_nxt = ne_nxt;
              mv_nxt = pick_r; mvup_nxt = 1'b0;
              mvend_nxt = IdxW'(count_r - 1'b1);
              pick_nxt = pick_r - 1'b1;
              ph_nxt = 3'd5;
              state_nxt = S_MVRD;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_MVRD: begin
        // up: copy mv-1 -> mv while mv > end; down: copy mv+1 -> mv while mv < end
        if (mvup_r ? (mv_r > mvend_r) : (mv_r < mvend_r)) begin
          raddr = mvup_r ? mv_r - 1'b1 : mv_r + 1'b1;
          state_nxt = S_MVWR;
        end else if (mvup_r) begin
          we = 1'b1; waddr = mvend_r; wdata = ne_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_FIN;
        end else begin
          count_nxt = count_r - 1'b1;
          // removed entry index is (ph 4) pick+1 or (ph 5) old pick
          if (rove_r > ((ph_r == 3'd4) ? pick1[IdxW-1:0] : pick_r + 1'b1))
            rove_nxt = rove_r - 1'b1;
          state_nxt = (ph_r == 3'd4) ? S_PRD : S_FIN;
          ph_nxt = (ph_r == 3'd4) ? 3'd2 : ph_r;
        end
      end
      S_MVWR: begin
        we = 1'b1; waddr = mv_r; wdata = rd_q;
        mv_nxt = mvup_r ? mv_r - 1'b1 : mv_r + 1'b1;
        state_nxt = S_MVRD;
      end
      S_FIN: begin
        we = 1'b1; waddr = pick_r; wdata = pe_r;
        if (cmd_r == CMD_ALLOC) begin
          wdata.free = 1'b0;
          rove_nxt = pick1[IdxW-1:0];
          if (pick1 >= count_r) rove_nxt = '0;
          ooff_nxt = pe_r.start[15:0];
        end else if ({{(CntW-IdxW){1'b0}}, rove_r} >= count_r) rove_nxt = '0;
        osz_nxt = pe_r.size[15:0];
        state_nxt = S_OUT;
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_BOOT;
      count_r <= CntW'(1);
      rove_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      rove_r <= rove_nxt;
    end
    if (state_r == S_IDLE && in_tvalid) begin
      cmd_r <= in_tdata[1:0];
      req_r <= {1'b0, in_tdata[17:2]};
      off_r <= in_tdata[33:18];
    end
    k_r <= k_nxt; i_r <= i_nxt; found_r <= found_nxt; pick_r <= pick_nxt;
    pe_r <= pe_nxt; ne_r <= ne_nxt; ph_r <= ph_nxt; mv_r <= mv_nxt;
    mvend_r <= mvend_nxt; mvup_r <= mvup_nxt;
    ost_r <= ost_nxt; ooff_r <= ooff_nxt; osz_r <= osz_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CntW'(1) && count_r <= CntW'(MaxBlocks))
    else $error("block count out of range");
  a_rove_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> {{(CntW-IdxW){1'b0}}, rove_r} < count_r)
    else $error("roving index past table");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ost_r != ST_OK |-> ooff_r == '0 && osz_r == '0)
    else $error("failed result carries data");
endmodule

### sim/free_list_block_allocator_tb.sv
`timescale 1ns / 1ps
module free_list_block_allocator_tb;
  import flba_pkg::*;

  localparam int NumRandom = 750;
  localparam int IdleLimit = 20000;
  localparam int SettleCycles = 600;

  typedef struct {
    status_t     status;
    logic [15:0] granted;
    logic [15:0] bsize;
  } grant_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] req;
    logic [15:0] off;
    logic        known;
    grant_t      res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  free_list_block_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // allocator shadow
  logic [16:0] tbl_start [MaxBlocks];
  logic [16:0] tbl_size [MaxBlocks];
  logic        tbl_free [MaxBlocks];
  int          n_blocks;
  int          rover;
  fit_t        policy;
  logic [15:0] arena_bytes;
  logic [15:0] live_offsets [$];

  grant_t      pending_grants [$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          n_results = 0;
  int          n_granted = 0;
  bit          stall_long = 1'b0;
  bit          quiet_rx = 1'b0;

  function automatic void arena_init();
    for (int k = 0; k < MaxBlocks; k++) begin
      tbl_start[k] = '0;
      tbl_size[k] = '0;
      tbl_free[k] = 1'b0;
    end
    tbl_start[0] = HeaderBytes;
    tbl_size[0] = (arena_bytes >= 16'd4) ? {1'b0, arena_bytes} - HeaderBytes : 17'd0;
    tbl_free[0] = 1'b1;
    n_blocks = 1;
    rover = 0;
  endfunction

  function automatic void drop_entry(int j);
    for (int k = j; k + 1 < n_blocks; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k] = tbl_size[k+1];
      tbl_free[k] = tbl_free[k+1];
    end
    n_blocks--;
    if (rover > j) rover--;
    if (rover >= n_blocks) rover = 0;
  endfunction

  function automatic grant_t allocator_step(cmd_t cmd, logic [15:0] req, logic [15:0] off);
    grant_t r;
    bit found;
    int pick, i;
    logic [16:0] need;
    r.status = ST_OK;
    r.granted = '0;
    r.bsize = '0;
    found = 0;
    pick = 0;
    need = {1'b0, req};
    case (cmd)
      CMD_INIT: begin
        arena_init();
        r.bsize = tbl_size[0][15:0];
      end
      CMD_ALLOC: begin
        if (rover >= n_blocks) rover = 0;
        for (int k = 0; k < n_blocks; k++) begin
          i = (policy == FIT_NEXT) ? (rover + k) % n_blocks : k;
          if (!tbl_free[i] || tbl_size[i] < need) continue;
          if (!found) begin
            found = 1;
            pick = i;
            if (policy == FIT_FIRST || policy == FIT_NEXT) break;
          end else if (policy == FIT_BEST && tbl_size[i] < tbl_size[pick]) begin
            pick = i;
          end else if (policy == FIT_WORST && tbl_size[i] > tbl_size[pick]) begin
            pick = i;
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
          return r;
        end
        if (tbl_size[pick] > need + HeaderBytes) begin
          if (n_blocks >= MaxBlocks) begin
            r.status = ST_FULL;
            return r;
          end
          for (int k = n_blocks; k > pick + 1; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_free[k] = tbl_free[k-1];
          end
          tbl_start[pick+1] = tbl_start[pick] + need + HeaderBytes;
          tbl_size[pick+1] = tbl_size[pick] - need - HeaderBytes;
          tbl_free[pick+1] = 1'b1;
          tbl_size[pick] = need;
          n_blocks++;
        end
        tbl_free[pick] = 1'b0;
        rover = pick + 1;
        if (rover >= n_blocks) rover = 0;
        r.granted = tbl_start[pick][15:0];
        r.bsize = tbl_size[pick][15:0];
      end
      CMD_FREE: begin
        for (i = 0; i < n_blocks; i++)
          if (tbl_start[i] == {1'b0, off} && !tbl_free[i]) break;
        if (i >= n_blocks) begin
          r.status = ST_BADFREE;
          return r;
        end
        tbl_free[i] = 1'b1;
        if (i + 1 < n_blocks && tbl_free[i+1]) begin
          tbl_size[i] = tbl_size[i] + tbl_size[i+1] + HeaderBytes;
          drop_entry(i + 1);
        end
        if (i > 0 && tbl_free[i-1]) begin
          tbl_size[i-1] = tbl_size[i-1] + tbl_size[i] + HeaderBytes;
          drop_entry(i);
          i--;
        end
        r.bsize = tbl_size[i][15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  // gap length: mostly none or short, occasionally long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT) policy = fit_t'(val[1:0]);
    else arena_bytes = val;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // offer one item, hold it until taken; expectation is queued at acceptance.
  // in_tvalid stays high after the taking edge; the next item or a gap
  // replaces it at that falling edge, and wait_drained drops it.
  task automatic send_cmd(cmd_t cmd, logic [15:0] req, logic [15:0] off,
                          bit known, grant_t typed, bit gaps);
    grant_t r;
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, off, req, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = allocator_step(cmd, req, off);
    if (known) begin
      if (r.status != typed.status) begin
        $error("table status exp %s got %s", typed.status.name(), r.status.name());
        fail_count++;
      end
      if (r.granted != typed.granted) begin
        $error("table granted_offset exp %0d got %0d", typed.granted, r.granted);
        fail_count++;
      end
      if (r.bsize != typed.bsize) begin
        $error("table block_size exp %0d got %0d", typed.bsize, r.bsize);
        fail_count++;
      end
    end
    pending_grants.push_back(r);
    if (cmd == CMD_ALLOC && r.status == ST_OK) live_offsets.push_back(r.granted);
    if (cmd == CMD_FREE && r.status == ST_OK)
      foreach (live_offsets[k])
        if (live_offsets[k] == off) begin
          live_offsets.delete(k);
          break;
        end
    if (cmd == CMD_INIT) live_offsets.delete();
    @(negedge clk);
  endtask

  // receiver
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        out_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        stall_long = 1'b0;
      end
      g = quiet_rx ? 0 : pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    grant_t e;
    grant_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.granted = out_tdata[17:2];
      got.bsize = out_tdata[33:18];
      n_results++;
      if (pending_grants.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        fail_count++;
      end else begin
        e = pending_grants.pop_front();
        if (got.status != e.status) begin
          $error("status exp %s got %s", e.status.name(), got.status.name());
          fail_count++;
        end
        if (got.granted != e.granted) begin
          $error("granted_offset exp %0d got %0d", e.granted, got.granted);
          fail_count++;
        end
        if (got.bsize != e.bsize) begin
          $error("block_size exp %0d got %0d", e.bsize, got.bsize);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("FAIL");
      $finish;
    end
  end

  function automatic grant_t mk(status_t s, logic [15:0] g, logic [15:0] b);
    grant_t r;
    r.status = s;
    r.granted = g;
    r.bsize = b;
    return r;
  endfunction

  function automatic stim_row_t row(cmd_t c, logic [15:0] q, logic [15:0] o, bit k, grant_t r);
    stim_row_t s;
    s.cmd = c;
    s.req = q;
    s.off = o;
    s.known = k;
    s.res = r;
    return s;
  endfunction

  task automatic random_phase(int count, int max_req, bit gaps);
    int p;
    logic [15:0] q, o;
    cmd_t c;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      o = '0;
      q = '0;
      if (p < 2) begin
        c = CMD_INIT;
      end else if (p < 3) begin
        c = CMD_NONE;
        q = 16'($urandom);
        o = 16'($urandom);
      end else if (p < 55) begin
        c = CMD_ALLOC;
        q = ($urandom_range(0, 30) == 0) ? 16'($urandom) : 16'($urandom_range(0, max_req));
        o = 16'($urandom);
      end else begin
        c = CMD_FREE;
        q = 16'($urandom);
        if (live_offsets.size() != 0 && $urandom_range(0, 9) != 0)
          o = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        else
          o = 16'($urandom);
      end
      send_cmd(c, q, o, 1'b0, mk(ST_OK, 0, 0), gaps);
    end
  endtask

  initial begin
    stim_row_t dir [$];
    policy = FIT_FIRST;
    arena_bytes = 16'd4096;
    arena_init();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    dir.push_back(row(CMD_ALLOC, 16'd16, 0, 1, mk(ST_OK, 16'd4, 16'd16)));
    dir.push_back(row(CMD_ALLOC, 16'd0, 0, 1, mk(ST_OK, 16'd24, 16'd0)));
    dir.push_back(row(CMD_ALLOC, 16'hFFFF, 0, 1, mk(ST_NOFIT, 0, 0)));
    dir.push_back(row(CMD_FREE, 16'd5, 16'd5, 1, mk(ST_BADFREE, 0, 0)));
    dir.push_back(row(CMD_FREE, 0, 16'd4, 1, mk(ST_OK, 0, 16'd16)));
    dir.push_back(row(CMD_FREE, 0, 16'd4, 1, mk(ST_BADFREE, 0, 0)));
    dir.push_back(row(CMD_FREE, 0, 16'd24, 0, mk(ST_OK, 0, 0)));
    dir.push_back(row(CMD_NONE, 16'hFFFF, 16'hFFFF, 1, mk(ST_OK, 0, 0)));
    dir.push_back(row(CMD_INIT, 0, 0, 1, mk(ST_OK, 0, 16'd4092)));
    dir.push_back(row(CMD_ALLOC, 16'd4092, 0, 1, mk(ST_OK, 16'd4, 16'd4092)));
    dir.push_back(row(CMD_ALLOC, 16'd1, 0, 1, mk(ST_NOFIT, 0, 0)));
    dir.push_back(row(CMD_FREE, 0, 16'd4, 1, mk(ST_OK, 0, 16'd4092)));
    // slack grant: remainder too small to split
    dir.push_back(row(CMD_ALLOC, 16'd4088, 0, 1, mk(ST_OK, 16'd4, 16'd4092)));
    dir.push_back(row(CMD_FREE, 0, 16'd4, 1, mk(ST_OK, 0, 16'd4092)));
    foreach (dir[k]) send_cmd(dir[k].cmd, dir[k].req, dir[k].off, dir[k].known, dir[k].res, 1);
    wait_drained();

    // small arena, then max arena
    write_reg(CFG_ARENA, 16'd3);
    send_cmd(CMD_INIT, 0, 0, 1, mk(ST_OK, 0, 16'd0), 1);
    send_cmd(CMD_ALLOC, 16'd0, 0, 1, mk(ST_OK, 16'd4, 16'd0), 1);
    wait_drained();
    write_reg(CFG_ARENA, 16'hFFFF);
    send_cmd(CMD_INIT, 0, 0, 1, mk(ST_OK, 0, 16'd65531), 1);
    // fill the table to hit the full status
    for (int k = 0; k < MaxBlocks + 2; k++) send_cmd(CMD_ALLOC, 16'd8, 0, 0, mk(ST_OK, 0, 0), 1);
    wait_drained();

    // random phases, cycling through the four fit policies with varied arena settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FIT, 16'(ph % 4));
      write_reg(CFG_ARENA, (ph == 5) ? 16'd8 : (ph == 4) ? 16'hFFFF : 16'($urandom_range(64, 2048)));
      send_cmd(CMD_INIT, 0, 0, 0, mk(ST_OK, 0, 0), 1);
      if (ph == 2) begin
        stall_long = 1'b1;
        random_phase(30, 64, 0);
      end else begin
        quiet_rx = (ph == 3);
        random_phase(NumRandom / 6, (ph == 4) ? 2000 : 96, ph != 1);
        quiet_rx = 1'b0;
      end
      wait_drained();
    end

    repeat (SettleCycles) @(negedge clk);
    $display("covered init/alloc/free under all four fit policies, arena 3..65535,");
    $display("%0d results checked, %0d live blocks at end", n_results, live_offsets.size());
    if (fail_count == 0 && pending_grants.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
